### rtl/nst_pkg.sv
// package for the named semaphore table
// shared types and status codes; no dependencies
package nst_pkg;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_POST  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_NOSEM   = 3'd1,
    ST_FULL    = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_QFULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_OUT
  } state_t;

  // search token passed along the cell chain
  typedef struct packed {
    logic hit_found;
    logic free_found;
  } token_t;

endpackage

### rtl/nst_cell.sv
// one semaphore entry of the table: key, count, open count and queue pointers
// depends on nst_pkg
module nst_cell #(
  parameter int QW = 4,
  parameter int QD = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [63:0]     key_in,
  input  nst_pkg::token_t tok_in,
  output nst_pkg::token_t tok_out,
  output logic            sel_hit,
  output logic            sel_free,
  input  logic            exec,
  input  logic            do_hit,
  input  logic            do_create,
  input  logic [1:0]      kind,
  input  logic [15:0]     init_value,
  output logic [15:0]     value,
  output logic [QW-1:0]   head,
  output logic [QW-1:0]   tail,
  output logic [QW:0]     fill
);
  import nst_pkg::*;

  logic        live;
  logic [63:0] key;
  logic        match;
  logic [7:0]  users;

  assign match    = live && key == key_in;
  assign sel_hit  = match && !tok_in.hit_found;
  assign sel_free = !live && !tok_in.free_found;
  assign tok_out.hit_found  = tok_in.hit_found | match;
  assign tok_out.free_found = tok_in.free_found | !live;

  always_ff @(posedge clk) begin
    if (rst) begin
      live  <= 1'b0;
      key   <= '0;
      value <= '0;
      users <= '0;
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
    end else if (exec) begin
      if (do_create) begin
        live  <= 1'b1;
        key   <= key_in;
        value <= init_value;
        users <= 8'd1;
        head  <= '0;
        tail  <= '0;
        fill  <= '0;
      end else if (do_hit) begin
        case (kind_t'(kind))
          KIND_OPEN: begin
            if (users != 8'hff) users <= users + 8'd1;
          end
          KIND_WAIT: begin
            if (value != 16'd0) value <= value - 16'd1;
            else if (fill < (QW+1)'(QD)) begin
              tail <= (tail == QW'(QD - 1)) ? '0 : tail + 1'b1;
              fill <= fill + 1'b1;
            end
          end
          KIND_POST: begin
            if (value != 16'hffff) value <= value + 16'd1;
            if (fill != '0) begin
              head <= (head == QW'(QD - 1)) ? '0 : head + 1'b1;
              fill <= fill - 1'b1;
            end
          end
          default: begin
            if (users <= 8'd1) begin
              live  <= 1'b0;
              key   <= '0;
              value <= '0;
              users <= '0;
              head  <= '0;
              tail  <= '0;
              fill  <= '0;
            end else begin
              users <= users - 8'd1;
            end
          end
        endcase
      end
    end
  end

endmodule

### rtl/named_semaphore_table.sv
// top level of the named semaphore table
// holds the request register, the cell chain, the waiter memory and the result register
// depends on nst_pkg and nst_cell
//
// usage:
//   s_axis carries one request item: kind, sem_name, init_value, caller_pid.
//   m_axis carries one result item per request: status, woken_valid, woken_pid.
//   each request passes through capture, chain lookup and waiter memory
//   read, entry update and result, in that order; the next request is
//   taken only once the result has been accepted, so the table does not
//   take a new request before it is through with the last one.
//   the lookup ripples combinationally through a chain of NUM_SEMS cells; the
//   first live match and first free entry are picked there.
//   waiter ids sit in one memory of NUM_SEMS << QW entries (QW the queue
//   pointer width) with one write and one registered read port.
//   reset empties the table at once; no clearing pass is needed.
//   when the receiver stalls the result stays in m_axis and no new request
//   is taken until it has been taken.
module named_semaphore_table #(
  parameter int NUM_SEMS    = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[1:0], sem_name[65:2], init_value[81:66], caller_pid[89:82], zero fill
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], woken_valid[3], woken_pid[11:4], zero fill
  output logic [15:0] m_axis_tdata
);
  import nst_pkg::*;

  localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int MD = NUM_SEMS << QW;

  state_t state, state_next;

  logic [1:0]  kind;
  logic [63:0] sem_name;
  logic [15:0] init_value;
  logic [7:0]  caller_pid;

  token_t tok [NUM_SEMS+1];
  logic [NUM_SEMS-1:0] hit_v, free_v;
  logic [15:0]   value_v [NUM_SEMS];
  logic [QW-1:0] head_v  [NUM_SEMS];
  logic [QW-1:0] tail_v  [NUM_SEMS];
  logic [QW:0]   fill_v  [NUM_SEMS];

  logic          hit_any, free_any;
  logic [SW-1:0] hit_idx, free_idx;
  logic          found;
  logic [SW-1:0] idx;
  logic [15:0]   cur_value;
  logic [QW-1:0] cur_tail;
  logic [QW:0]   cur_fill;

  logic [7:0]    waiters [MD];
  logic [7:0]    rd_pid;
  logic [SW+QW-1:0] rd_addr;

  logic [2:0] status;
  logic       woken_valid;
  logic [7:0] woken_pid;
  logic       exec;

  assign tok[0] = '0;

  for (genvar g = 0; g < NUM_SEMS; g++) begin : g_cell
    nst_cell #(.QW(QW), .QD(QUEUE_DEPTH)) u_cell (
      .clk(clk), .rst(rst),
      .key_in(sem_name),
      .tok_in(tok[g]), .tok_out(tok[g+1]),
      .sel_hit(hit_v[g]), .sel_free(free_v[g]),
      .exec(exec),
      .do_hit(found && idx == SW'(g)),
      .do_create(!found && free_any && kind_t'(kind) == KIND_OPEN && free_idx == SW'(g)),
      .kind(kind), .init_value(init_value),
      .value(value_v[g]),
      .head(head_v[g]), .tail(tail_v[g]), .fill(fill_v[g])
    );
  end

  always_comb begin
    hit_idx = '0;
    free_idx = '0;
    for (int i = 0; i < NUM_SEMS; i++) begin
      if (hit_v[i]) hit_idx = SW'(i);
      if (free_v[i]) free_idx = SW'(i);
    end
  end

  assign hit_any  = tok[NUM_SEMS].hit_found;
  assign free_any = tok[NUM_SEMS].free_found;

  // lookup result is registered at the end of the scan cycle
  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      found     <= hit_any;
      idx       <= hit_idx;
      cur_value <= value_v[hit_idx];
      cur_tail  <= tail_v[hit_idx];
      cur_fill  <= fill_v[hit_idx];
    end
  end

  assign rd_addr = {hit_idx, head_v[hit_idx]};

  always_ff @(posedge clk) begin
    if (state == S_SCAN) rd_pid <= waiters[rd_addr];
    if (exec && found && kind_t'(kind) == KIND_WAIT && cur_value == 16'd0
        && cur_fill < (QW+1)'(QUEUE_DEPTH))
      waiters[{idx, cur_tail}] <= caller_pid;
  end

  assign exec = state == S_EXEC;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_SCAN;
      S_SCAN: state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT:  if (m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign s_axis_tready = state == S_IDLE;
  assign m_axis_tvalid = state == S_OUT;
  assign m_axis_tdata  = {4'd0, woken_pid, woken_valid, status};

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind       <= s_axis_tdata[1:0];
      sem_name   <= s_axis_tdata[65:2];
      init_value <= s_axis_tdata[81:66];
      caller_pid <= s_axis_tdata[89:82];
    end
    if (exec) begin
      status      <= ST_DONE;
      woken_valid <= 1'b0;
      woken_pid   <= 8'd0;
      if (kind_t'(kind) == KIND_OPEN) begin
        if (!found && !free_any) status <= ST_FULL;
      end else if (!found) begin
        status <= ST_NOSEM;
      end else if (kind_t'(kind) == KIND_WAIT) begin
        if (cur_value == 16'd0) begin
          if (cur_fill >= (QW+1)'(QUEUE_DEPTH)) status <= ST_QFULL;
          else status <= ST_BLOCKED;
        end
      end else if (kind_t'(kind) == KIND_POST) begin
        if (cur_fill != '0) begin
          woken_valid <= 1'b1;
          woken_pid   <= rd_pid;
        end
      end
    end
  end

endmodule

### verif/named_semaphore_table_test.sv
// testbench for the named semaphore table: directed table and directed sequences, then random requests
// predicts each result with its own table model; depends on nst_pkg and named_semaphore_table
`timescale 1ns / 100ps

module named_semaphore_table_test;
  import nst_pkg::*;

  localparam int NSEM = 16;
  localparam int QDEP = 16;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    kind_t       kind;
    logic [63:0] key;
    logic [15:0] init;
    logic [7:0]  pid;
  } request_t;

  typedef struct {
    status_t    status;
    logic       woken_valid;
    logic [7:0] woken_pid;
  } reply_t;

  typedef struct {
    request_t req;
    logic     known;
    reply_t   rep;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // kind[1:0], sem_name[65:2], init_value[81:66], caller_pid[89:82], zero fill
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // status[2:0], woken_valid[3], woken_pid[11:4], zero fill
  logic [15:0] m_axis_tdata;

  named_semaphore_table dut (.*);

  logic        live [NSEM];
  logic [63:0] keys [NSEM];
  logic [15:0] count [NSEM];
  logic [7:0]  users [NSEM];
  logic [7:0]  waiters [NSEM][QDEP];
  int          head [NSEM];
  int          tail [NSEM];
  int          fill [NSEM];

  reply_t pending_replies[$];
  int     failures;
  int     replies_seen;
  int     wakes_seen;
  longint cycles;
  logic   rx_idle;
  logic [63:0] key_pool [8];

  function automatic reply_t predict_reply(request_t r);
    reply_t o;
    int idx;
    o.status = ST_DONE;
    o.woken_valid = 1'b0;
    o.woken_pid = 8'd0;
    idx = -1;
    for (int i = 0; i < NSEM; i++)
      if (idx < 0 && live[i] && keys[i] == r.key) idx = i;
    if (r.kind == KIND_OPEN) begin
      if (idx < 0) begin
        for (int i = 0; i < NSEM; i++)
          if (idx < 0 && !live[i]) idx = i;
        if (idx >= 0) begin
          live[idx] = 1'b1;
          keys[idx] = r.key;
          count[idx] = r.init;
          users[idx] = 8'd0;
          head[idx] = 0;
          tail[idx] = 0;
          fill[idx] = 0;
        end
      end
      if (idx < 0) o.status = ST_FULL;
      else if (users[idx] != 8'hff) users[idx]++;
    end else if (idx < 0) begin
      o.status = ST_NOSEM;
    end else if (r.kind == KIND_WAIT) begin
      if (count[idx] > 0) count[idx]--;
      else if (fill[idx] >= QDEP) o.status = ST_QFULL;
      else begin
        waiters[idx][tail[idx]] = r.pid;
        tail[idx] = (tail[idx] + 1) % QDEP;
        fill[idx]++;
        o.status = ST_BLOCKED;
      end
    end else if (r.kind == KIND_POST) begin
      if (count[idx] != 16'hffff) count[idx]++;
      if (fill[idx] > 0) begin
        o.woken_valid = 1'b1;
        o.woken_pid = waiters[idx][head[idx]];
        head[idx] = (head[idx] + 1) % QDEP;
        fill[idx]--;
      end
    end else begin
      if (users[idx] <= 1) begin
        live[idx] = 1'b0;
        keys[idx] = 64'd0;
        count[idx] = 16'd0;
        users[idx] = 8'd0;
        head[idx] = 0;
        tail[idx] = 0;
        fill[idx] = 0;
      end else begin
        users[idx]--;
      end
    end
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        replies_seen++;
        if (pending_replies.size() == 0) begin
          $error("result item with no request pending: %h", m_axis_tdata);
          failures++;
        end else begin
          reply_t e;
          e = pending_replies.pop_front();
          if (m_axis_tdata[2:0] !== e.status) begin
            $error("status expected %0d got %0d", e.status, m_axis_tdata[2:0]);
            failures++;
          end
          if (m_axis_tdata[3] !== e.woken_valid) begin
            $error("woken_valid expected %0d got %0d", e.woken_valid, m_axis_tdata[3]);
            failures++;
          end
          if (m_axis_tdata[11:4] !== e.woken_pid) begin
            $error("woken_pid expected %0d got %0d", e.woken_pid, m_axis_tdata[11:4]);
            failures++;
          end
          if (e.woken_valid) wakes_seen++;
        end
      end
      if (rx_idle) m_axis_tready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 99) < 40) m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_request(request_t r, logic known, reply_t given);
    reply_t p;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap + 1) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, r.pid, r.init, r.key, r.kind};
    do @(posedge clk); while (!s_axis_tready);
    p = predict_reply(r);
    if (known && (p.status != given.status || p.woken_valid != given.woken_valid ||
                  p.woken_pid != given.woken_pid)) begin
      $error("predictor disagrees with table row, kind %0d", r.kind);
      failures++;
    end
    pending_replies.push_back(p);
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic request_t make_req(kind_t k, logic [63:0] key, logic [15:0] init,
                                        logic [7:0] pid);
    request_t r;
    r.kind = k; r.key = key; r.init = init; r.pid = pid;
    return r;
  endfunction

  function automatic reply_t make_rep(status_t s, logic v, logic [7:0] p);
    reply_t o;
    o.status = s; o.woken_valid = v; o.woken_pid = p;
    return o;
  endfunction

  directed_row_t rows[$];

  initial begin
    request_t r;
    int pick;
    failures = 0;
    replies_seen = 0;
    wakes_seen = 0;
    cycles = 0;
    rx_idle = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    for (int i = 0; i < NSEM; i++) begin
      live[i] = 0; keys[i] = 0; count[i] = 0; users[i] = 0;
      head[i] = 0; tail[i] = 0; fill[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unknown key, extremes, blocking, wake order, saturation, close
    rows.push_back('{make_req(KIND_WAIT, 64'hffff_ffff_ffff_ffff, 16'hffff, 8'hff), 1,
                     make_rep(ST_NOSEM, 0, 0)});
    rows.push_back('{make_req(KIND_POST, 64'd0, 16'd0, 8'd0), 1, make_rep(ST_NOSEM, 0, 0)});
    rows.push_back('{make_req(KIND_CLOSE, 64'd5, 16'd0, 8'd0), 1, make_rep(ST_NOSEM, 0, 0)});
    rows.push_back('{make_req(KIND_OPEN, 64'd0, 16'd0, 8'd0), 1, make_rep(ST_DONE, 0, 0)});
    rows.push_back('{make_req(KIND_WAIT, 64'd0, 16'hffff, 8'hff), 1,
                     make_rep(ST_BLOCKED, 0, 0)});
    rows.push_back('{make_req(KIND_WAIT, 64'd0, 16'd0, 8'h5a), 1, make_rep(ST_BLOCKED, 0, 0)});
    rows.push_back('{make_req(KIND_POST, 64'd0, 16'd0, 8'd0), 1, make_rep(ST_DONE, 1, 8'hff)});
    rows.push_back('{make_req(KIND_POST, 64'd0, 16'd0, 8'd0), 1, make_rep(ST_DONE, 1, 8'h5a)});
    rows.push_back('{make_req(KIND_WAIT, 64'd0, 16'd0, 8'd1), 0, make_rep(ST_DONE, 0, 0)});
    rows.push_back('{make_req(KIND_OPEN, 64'hffff_ffff_ffff_ffff, 16'hffff, 8'd0), 1,
                     make_rep(ST_DONE, 0, 0)});
    rows.push_back('{make_req(KIND_POST, 64'hffff_ffff_ffff_ffff, 16'd0, 8'd0), 1,
                     make_rep(ST_DONE, 0, 0)});
    rows.push_back('{make_req(KIND_WAIT, 64'hffff_ffff_ffff_ffff, 16'd0, 8'd0), 0,
                     make_rep(ST_DONE, 0, 0)});
    rows.push_back('{make_req(KIND_OPEN, 64'd0, 16'h1234, 8'd0), 0, make_rep(ST_DONE, 0, 0)});
    rows.push_back('{make_req(KIND_CLOSE, 64'd0, 16'd0, 8'd0), 0, make_rep(ST_DONE, 0, 0)});
    rows.push_back('{make_req(KIND_CLOSE, 64'd0, 16'd0, 8'd0), 0, make_rep(ST_DONE, 0, 0)});
    rows.push_back('{make_req(KIND_WAIT, 64'd0, 16'd0, 8'd0), 1, make_rep(ST_NOSEM, 0, 0)});
    rows.push_back('{make_req(KIND_CLOSE, 64'hffff_ffff_ffff_ffff, 16'd0, 8'd0), 0,
                     make_rep(ST_DONE, 0, 0)});
    foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].rep);

    // queue full on one entry
    send_request(make_req(KIND_OPEN, 64'h77, 16'd0, 8'd0), 0, make_rep(ST_DONE, 0, 0));
    for (int i = 0; i <= QDEP; i++)
      send_request(make_req(KIND_WAIT, 64'h77, 16'd0, i[7:0]), 0, make_rep(ST_DONE, 0, 0));
    // table full
    for (int i = 0; i <= NSEM; i++)
      send_request(make_req(KIND_OPEN, 64'h1000 + i, 16'd3, 8'd0), 0, make_rep(ST_DONE, 0, 0));
    // open count saturation on one entry
    for (int i = 0; i < 258; i++)
      send_request(make_req(KIND_OPEN, 64'h1000, 16'd0, 8'd0), 0, make_rep(ST_DONE, 0, 0));

    // sender holds off until the table has answered everything
    wait (pending_replies.size() == 0);
    for (int i = 0; i < NSEM; i++) begin
      send_request(make_req(KIND_CLOSE, 64'h77, 16'd0, 8'd0), 0, make_rep(ST_DONE, 0, 0));
      send_request(make_req(KIND_CLOSE, 64'h1000 + i, 16'd0, 8'd0), 0,
                   make_rep(ST_DONE, 0, 0));
    end

    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 400 == 399) rx_idle = !rx_idle;
      pick = $urandom_range(0, 99);
      r.kind = kind_t'($urandom_range(0, 99) < 20 ? KIND_OPEN :
               $urandom_range(0, 2) == 0 ? KIND_WAIT :
               $urandom_range(0, 1) == 0 ? KIND_POST :
               ($urandom_range(0, 3) == 0 ? KIND_CLOSE : KIND_WAIT));
      if (pick < 85) r.key = key_pool[$urandom_range(0, 7)];
      else r.key = {$urandom, $urandom};
      r.init = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
      if ($urandom_range(0, 19) == 0) r.init = 16'hffff;
      r.pid = 8'($urandom);
      send_request(r, 1'b0, make_rep(ST_DONE, 0, 0));
    end

    wait (pending_replies.size() == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d results, %0d of them releasing a queued caller",
             replies_seen, wakes_seen);
    if (failures == 0 && pending_replies.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
